// ===== hw/rtl/bba_pkg.sv =====
// Shared constants, codes, control structs and helper functions of the block allocator.
`default_nettype none

package bba_pkg;

   // Bitmap geometry: the used map is kept as rows of ROW_BITS bits.
   localparam int MAX_BLOCKS      = 256;
   localparam int ROW_BITS        = 16;
   localparam int ROWS            = MAX_BLOCKS / ROW_BITS;
   localparam int ROW_AW          = $clog2(ROWS);
   localparam int BIT_AW          = $clog2(ROW_BITS);
   localparam int BLK_AW          = ROW_AW + BIT_AW;
   localparam int CNT_W           = $clog2(MAX_BLOCKS + 1);

   // Request limits.
   localparam int MAX_PER_REQUEST = 16;
   localparam int GOT_W           = $clog2(MAX_PER_REQUEST + 1);
   localparam int MAX_BLOCK_BYTES = 64;

   // Field and register widths.
   localparam int SIZE_W          = 12;
   localparam int IDX_W           = 8;
   localparam int TOTAL_W         = 9;
   localparam int BS_W            = 7;
   localparam int NUM_W           = SIZE_W + 1;
   localparam int DIV_STEPS       = NUM_W;
   localparam int DIV_CNT_W       = $clog2(DIV_STEPS);
   localparam int CSR_DATA_W      = 9;

   // Register defaults and the values that a zero setting stands for.
   localparam logic [TOTAL_W-1:0] TOTAL_RESET   = TOTAL_W'(16);
   localparam logic [TOTAL_W-1:0] TOTAL_ZERO_AS = TOTAL_W'(16);
   localparam logic [BS_W-1:0]    BS_RESET      = BS_W'(32);
   localparam logic [BS_W-1:0]    BS_ZERO_AS    = BS_W'(32);

   // Stream packing.
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_SPACE = 2'd1,
      ST_ZERO     = 2'd2,
      ST_RANGE    = 2'd3
   } rsp_status_type;

   typedef enum logic {
      CSR_TOTAL_BLOCKS = 1'b0,
      CSR_BLOCK_SIZE   = 1'b1
   } csr_index_type;

   typedef enum logic {
      ACT_ALLOC = 1'b0,
      ACT_FREE  = 1'b1
   } action_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic           accept;     // latch the request beat, start the divider
      logic           cnt_step;   // read row at pointer for counting, advance pointer
      logic           ptr_clear;
      logic           ptr_inc;
      logic           rd_ptr;     // read row at pointer
      logic           rd_idx;     // read row that holds the block to release
      logic           free_wr;    // write back that row with the block cleared
      logic           set_free;   // free count = total - used
      logic           take_need;  // free count = total - used - need
      logic           work_load;
      logic           work_wr;
      logic           claim;      // take lowest free block of the work row, send it
      logic           emit;       // send a single closing result
      rsp_status_type emit_status;
   } bba_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_free;
      logic size_zero;
      logic idx_oob;
      logic no_space;
      logic div_done;
      logic ptr_last;
      logic work_has_free;
      logic got_done;
      logic out_ready;
   } bba_stat_type;

   // Bits of a row whose block number lies below the block count.
   function automatic logic [ROW_BITS-1:0] row_mask(input logic [ROW_AW-1:0] row,
                                                    input logic [CNT_W-1:0]  total);
      logic [ROW_BITS-1:0] mask;
      logic [CNT_W-1:0]    blk;
      mask = '0;
      for (int j = 0; j < ROW_BITS; j++) begin
         blk     = CNT_W'({row, BIT_AW'(j)});
         mask[j] = (blk < total);
      end
      return mask;
   endfunction

   // Number of set bits in a row.
   function automatic logic [BIT_AW:0] row_popcount(input logic [ROW_BITS-1:0] v);
      logic [BIT_AW:0] sum;
      sum = '0;
      for (int j = 0; j < ROW_BITS; j++) begin
         sum = sum + (BIT_AW+1)'(v[j]);
      end
      return sum;
   endfunction

   // Position of the lowest set bit of a row.
   function automatic logic [BIT_AW-1:0] row_lowest(input logic [ROW_BITS-1:0] v);
      logic [BIT_AW-1:0] pos;
      pos = '0;
      for (int j = ROW_BITS - 1; j >= 0; j--) begin
         if (v[j]) begin
            pos = BIT_AW'(j);
         end
      end
      return pos;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bba_div.sv =====
// Restoring divider, one quotient bit per cycle, for the block count of a request.
`default_nettype none

module bba_div
   import bba_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numer,
   input  wire logic [BS_W-1:0]  denom,
   output logic      [NUM_W-1:0] quotient,
   output logic                  done
);

   logic [NUM_W-1:0]     quo_ff, quo_in;
   logic [BS_W-1:0]      rem_ff, rem_in;
   logic [BS_W-1:0]      den_ff;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [BS_W:0]        trial;
   logic                 fits;

   // One restoring step: bring down the next numerator bit and try a subtract.
   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      fits    = (trial >= {1'b0, den_ff});
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = numer;
         rem_in  = '0;
         cnt_in  = DIV_CNT_W'(DIV_STEPS - 1);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], fits};
         rem_in = fits ? BS_W'(trial - {1'b0, den_ff}) : trial[BS_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (start) begin
         den_ff <= denom;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/bba_dp.sv =====
// Datapath: settings, used-map row memory, counters, divider and result register.
`default_nettype none

module bba_dp
   import bba_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bba_cmd_type           cmd,
   output bba_stat_type               stat,
   input  wire logic                  in_action,
   input  wire logic [SIZE_W-1:0]     in_byte_size,
   input  wire logic [IDX_W-1:0]      in_block_index,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire logic                  rsp_tready,
   output logic                       rsp_tvalid,
   output logic [IDX_W-1:0]           out_granted_block,
   output rsp_status_type             out_status,
   output logic                       out_last,
   output logic [CNT_W-1:0]           out_free_blocks
);

   // Settings and their effective values.
   logic [TOTAL_W-1:0] total_ff;
   logic [BS_W-1:0]    bs_ff;
   logic [CNT_W-1:0]   t_eff;
   logic [BS_W-1:0]    bs_eff;

   // Latched request beat.
   logic               act_ff;
   logic [SIZE_W-1:0]  size_ff;
   logic [IDX_W-1:0]   idx_ff;

   // Row memory with one valid bit per row; an unwritten row reads as all free.
   logic [ROW_BITS-1:0] map_mem [ROWS];
   logic [ROWS-1:0]     row_vld_ff;
   logic [ROW_BITS-1:0] rd_data_ff;
   logic                rd_ok_ff;
   logic [ROW_BITS-1:0] rd_eff;
   logic                rd_en;
   logic [ROW_AW-1:0]   rd_addr;
   logic                wr_en;
   logic [ROW_AW-1:0]   wr_addr;
   logic [ROW_BITS-1:0] wr_data;

   // Counting and allocation state.
   logic [ROW_AW-1:0]   ptr_ff;
   logic                cnt_tag_ff;
   logic [ROW_AW-1:0]   rd_row_ff;
   logic [CNT_W-1:0]    used_ff;
   logic [CNT_W-1:0]    free_ff;
   logic [CNT_W-1:0]    free_now;
   logic [ROW_BITS-1:0] work_ff;
   logic [ROW_BITS-1:0] work_avail;
   logic [BIT_AW-1:0]   pick;
   logic [GOT_W-1:0]    got_ff;
   logic [GOT_W-1:0]    need_small;
   logic [CNT_W-1:0]    t_m1;
   logic [ROW_AW-1:0]   last_row;
   logic                idx_bit;

   // Divider.
   logic [NUM_W-1:0]    numer;
   logic [NUM_W-1:0]    need;
   logic                div_done;

   // Result register.
   logic                rsp_valid_ff;
   logic [IDX_W-1:0]    granted_ff;
   rsp_status_type      status_ff;
   logic                last_ff;
   logic [CNT_W-1:0]    free_out_ff;
   logic                out_ready;

   // Effective settings: zero takes the default, large values are capped.
   always_comb begin
      if (total_ff == '0) begin
         t_eff = CNT_W'(TOTAL_ZERO_AS);
      end else if (CNT_W'(total_ff) > CNT_W'(MAX_BLOCKS)) begin
         t_eff = CNT_W'(MAX_BLOCKS);
      end else begin
         t_eff = CNT_W'(total_ff);
      end
      if (bs_ff == '0) begin
         bs_eff = BS_ZERO_AS;
      end else if (bs_ff > BS_W'(MAX_BLOCK_BYTES)) begin
         bs_eff = BS_W'(MAX_BLOCK_BYTES);
      end else begin
         bs_eff = bs_ff;
      end
   end

   // Settings registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= TOTAL_RESET;
         bs_ff    <= BS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TOTAL_BLOCKS: total_ff <= csr_data[TOTAL_W-1:0];
            CSR_BLOCK_SIZE:   bs_ff    <= csr_data[BS_W-1:0];
            default:          total_ff <= total_ff;
         endcase
      end
   end

   // Block count of a request: ceil(size / block size).
   assign numer = NUM_W'(in_byte_size) + NUM_W'(bs_eff) - NUM_W'(1);

   bba_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.accept),
      .numer    (numer),
      .denom    (bs_eff),
      .quotient (need),
      .done     (div_done)
   );

   // Request beat capture.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         act_ff  <= in_action;
         size_ff <= in_byte_size;
         idx_ff  <= in_block_index;
      end
   end

   // Memory addressing and write data.
   assign rd_en   = cmd.cnt_step | cmd.rd_ptr | cmd.rd_idx;
   assign rd_addr = cmd.rd_idx ? idx_ff[IDX_W-1:BIT_AW] : ptr_ff;
   assign rd_eff  = rd_ok_ff ? rd_data_ff : '0;
   assign idx_bit = rd_eff[idx_ff[BIT_AW-1:0]];

   always_comb begin
      wr_en   = cmd.free_wr | cmd.work_wr;
      wr_addr = ptr_ff;
      wr_data = work_ff;
      if (cmd.free_wr) begin
         wr_addr = idx_ff[IDX_W-1:BIT_AW];
         wr_data = rd_eff;
         wr_data[idx_ff[BIT_AW-1:0]] = 1'b0;
      end
   end

   // Row memory, registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= map_mem[rd_addr];
      end
   end

   // Row valid bits; reset marks every row as all free.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
         rd_ok_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            row_vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_ok_ff <= row_vld_ff[rd_addr];
         end
      end
   end

   // Counters: row pointer, used count, free count, blocks granted.
   assign free_now   = t_eff - used_ff;
   assign work_avail = ~work_ff & row_mask(ptr_ff, t_eff);
   assign pick       = row_lowest(work_avail);
   assign need_small = need[GOT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_tag_ff <= 1'b0;
      end else begin
         cnt_tag_ff <= cmd.cnt_step;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cnt_step) begin
         rd_row_ff <= ptr_ff;
      end
      if (cmd.accept || cmd.ptr_clear) begin
         ptr_ff <= '0;
      end else if (cmd.cnt_step || cmd.ptr_inc) begin
         ptr_ff <= ptr_ff + 1'b1;
      end
      if (cmd.accept) begin
         used_ff <= '0;
      end else if (cnt_tag_ff) begin
         used_ff <= used_ff + CNT_W'(row_popcount(rd_eff & row_mask(rd_row_ff, t_eff)));
      end
      if (cmd.take_need) begin
         free_ff <= free_now - CNT_W'(need_small);
      end else if (cmd.set_free) begin
         free_ff <= free_now;
      end else if (cmd.free_wr && idx_bit) begin
         free_ff <= free_ff + 1'b1;
      end
      if (cmd.accept) begin
         got_ff <= '0;
      end else if (cmd.claim) begin
         got_ff <= got_ff + 1'b1;
      end
      if (cmd.work_load) begin
         work_ff <= rd_eff;
      end else if (cmd.claim) begin
         work_ff[pick] <= 1'b1;
      end
   end

   // Result register; it loads whenever it is empty or being drained.
   assign out_ready = ~rsp_valid_ff | rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.claim || cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.claim) begin
         granted_ff  <= IDX_W'({ptr_ff, pick});
         status_ff   <= ST_OK;
         last_ff     <= (GOT_W'(got_ff + 1'b1) == need_small);
         free_out_ff <= free_ff;
      end else if (cmd.emit) begin
         granted_ff  <= '0;
         status_ff   <= cmd.emit_status;
         last_ff     <= 1'b1;
         free_out_ff <= free_ff;
      end
   end

   // Status toward the controller.
   assign t_m1     = t_eff - 1'b1;
   assign last_row = t_m1[BLK_AW-1:BIT_AW];

   always_comb begin
      stat.is_free       = (act_ff == ACT_FREE);
      stat.size_zero     = (size_ff == '0);
      stat.idx_oob       = (CNT_W'(idx_ff) >= t_eff);
      stat.no_space      = (need > NUM_W'(MAX_PER_REQUEST)) || (need > NUM_W'(free_now));
      stat.div_done      = div_done;
      stat.ptr_last      = (ptr_ff == last_row);
      stat.work_has_free = |work_avail;
      stat.got_done      = (got_ff == need_small);
      stat.out_ready     = out_ready;
   end

   assign rsp_tvalid        = rsp_valid_ff;
   assign out_granted_block = granted_ff;
   assign out_status        = status_ff;
   assign out_last          = last_ff;
   assign out_free_blocks   = free_out_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/bba_ctrl.sv =====
// Controller state machine that sequences counting, releasing and allocating.
`default_nettype none

module bba_ctrl
   import bba_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire bba_stat_type stat,
   output bba_cmd_type       cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_CNT,
      S_CNT_END,
      S_DECIDE,
      S_FR_RD,
      S_FR_WR,
      S_AL_RD,
      S_AL_LOAD,
      S_AL_PICK,
      S_EMIT
   } state_type;

   state_type      state_ff, state_in;
   rsp_status_type status_ff, status_in;

   // Next state and commands.
   always_comb begin
      state_in        = state_ff;
      status_in       = status_ff;
      cmd             = '0;
      cmd.emit_status = status_ff;
      req_tready      = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_CNT;
            end
         end
         // Sweep the rows in range and add up the used blocks.
         S_CNT: begin
            cmd.cnt_step = 1'b1;
            if (stat.ptr_last) begin
               state_in = S_CNT_END;
            end
         end
         S_CNT_END: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.set_free = 1'b1;
            if (stat.is_free) begin
               if (stat.idx_oob) begin
                  status_in = ST_RANGE;
                  state_in  = S_EMIT;
               end else begin
                  state_in  = S_FR_RD;
               end
            end else if (stat.size_zero) begin
               status_in = ST_ZERO;
               state_in  = S_EMIT;
            end else if (stat.div_done) begin
               if (stat.no_space) begin
                  status_in = ST_NO_SPACE;
                  state_in  = S_EMIT;
               end else begin
                  cmd.set_free  = 1'b0;
                  cmd.take_need = 1'b1;
                  cmd.ptr_clear = 1'b1;
                  state_in      = S_AL_RD;
               end
            end
         end
         // Release one block.
         S_FR_RD: begin
            cmd.rd_idx = 1'b1;
            state_in   = S_FR_WR;
         end
         S_FR_WR: begin
            cmd.free_wr = 1'b1;
            status_in   = ST_OK;
            state_in    = S_EMIT;
         end
         // First-fit scan: load a row, hand out its free blocks, write it back.
         S_AL_RD: begin
            cmd.rd_ptr = 1'b1;
            state_in   = S_AL_LOAD;
         end
         S_AL_LOAD: begin
            cmd.work_load = 1'b1;
            state_in      = S_AL_PICK;
         end
         S_AL_PICK: begin
            if (stat.got_done) begin
               cmd.work_wr = 1'b1;
               state_in    = S_IDLE;
            end else if (stat.work_has_free) begin
               cmd.claim = stat.out_ready;
            end else begin
               cmd.work_wr = 1'b1;
               cmd.ptr_inc = 1'b1;
               state_in    = S_AL_RD;
            end
         end
         // Single closing result.
         S_EMIT: begin
            if (stat.out_ready) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered status code.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= ST_OK;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_block_allocator.sv =====
// Top level of the first-fit bitmap block allocator.
//
// The req channel takes one beat per request: tuser is the action (allocate or
// free one block), tdata carries the byte size and the block index. The rsp
// channel returns one beat per granted block for an allocation, with tlast on
// the final one, and a single beat with tlast for every other outcome. Each
// result also reports the free block count after the request. The csr channel
// sets the block count and the block size; write it only while idle.
// A request is taken only when the previous one is finished. Every request
// first counts the used blocks of the rows in use, ceil(total/16) rows of
// 16 blocks, one row per cycle. A free then reads the row of its block and
// writes it back with the block cleared; an out-of-range index or a zero
// size goes straight to its result. An allocation decides once the divider
// is done: a refusal for space then sends its result, and a grant scans the
// rows in turn: it reads and loads each row, hands out its free blocks and
// writes the row back before it moves on to the next one.
// Reset clears the whole map at once (every block free) and restores the
// default settings of 16 blocks of 32 bytes. A result waits in the output
// register while rsp_tready is low; the scan holds until the register drains.
`default_nettype none

module bitmap_block_allocator
   import bba_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Request beats.
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // byte_size[11:0], block_index[19:12]
   input  wire logic                   req_tuser,  // action[0]
   // Result beats.
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,  // granted_block[7:0], free_blocks[16:8]
   output logic [1:0]                  rsp_tuser,  // status[1:0]
   output logic                        rsp_tlast,
   // Settings writes.
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic                   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   bba_cmd_type    cmd;
   bba_stat_type   stat;
   logic [IDX_W-1:0] granted_block;
   rsp_status_type status;
   logic [CNT_W-1:0] free_blocks;

   assign csr_ready = 1'b1;

   bba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bba_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .in_action         (req_tuser),
      .in_byte_size      (req_tdata[SIZE_W-1:0]),
      .in_block_index    (req_tdata[SIZE_W+IDX_W-1:SIZE_W]),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_tready        (rsp_tready),
      .rsp_tvalid        (rsp_tvalid),
      .out_granted_block (granted_block),
      .out_status        (status),
      .out_last          (rsp_tlast),
      .out_free_blocks   (free_blocks)
   );

   // Result packing, padded with zeros to whole bytes.
   assign rsp_tdata = RSP_TDATA_W'({free_blocks, granted_block});
   assign rsp_tuser = status;

endmodule

`default_nettype wire

// ===== test/tb_bitmap_block_allocator.sv =====
// Self-checking testbench of the first-fit bitmap block allocator.
`timescale 1ns / 100ps

module tb_bitmap_block_allocator;
   import bba_pkg::*;

   // One request beat as the stimulus sees it.
   typedef struct {
      action_type         action;
      logic [SIZE_W-1:0]  byte_size;
      logic [IDX_W-1:0]   block_index;
   } alloc_req_type;

   // One result beat as the block should return it.
   typedef struct {
      logic [IDX_W-1:0]   granted;
      rsp_status_type     status;
      logic               last;
      logic [CNT_W-1:0]   free_cnt;
   } alloc_rsp_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata = '0;
   logic                    req_tuser = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic [1:0]              rsp_tuser;
   logic                    rsp_tlast;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   csr_index_type           csr_index = CSR_TOTAL_BLOCKS;
   logic [CSR_DATA_W-1:0]   csr_data = '0;

   // Shadow copy of the allocator state and its settings.
   bit                      shadow_used [MAX_BLOCKS];
   logic [TOTAL_W-1:0]      cfg_total = TOTAL_RESET;
   logic [BS_W-1:0]         cfg_bsize = BS_RESET;

   alloc_req_type           req_backlog [$];
   alloc_req_type           req_cur;
   alloc_rsp_type           due_results [$];
   int unsigned             send_idle_pct = 0;
   int unsigned             recv_idle_pct = 0;
   logic                    rsp_hold = 1'b0;
   int unsigned             mismatch_count = 0;
   int unsigned             rsp_beats = 0;

   bitmap_block_allocator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // byte_size[11:0], block_index[19:12]
      .req_tuser  (req_tuser),   // action[0]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // granted_block[7:0], free_blocks[16:8]
      .rsp_tuser  (rsp_tuser),   // status[1:0]
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Block count in force: zero means the default, large values saturate.
   function automatic int unsigned eff_total();
      int unsigned t;
      t = cfg_total;
      if (t == 0) t = TOTAL_ZERO_AS;
      if (t > MAX_BLOCKS) t = MAX_BLOCKS;
      return t;
   endfunction

   function automatic int unsigned eff_bsize();
      int unsigned b;
      b = cfg_bsize;
      if (b == 0) b = BS_ZERO_AS;
      if (b > MAX_BLOCK_BYTES) b = MAX_BLOCK_BYTES;
      return b;
   endfunction

   // Clear bits among the blocks in use.
   function automatic int unsigned blocks_free();
      int unsigned n;
      int unsigned i;
      n = 0;
      for (i = 0; i < eff_total(); i++) begin
         if (!shadow_used[i]) n++;
      end
      return n;
   endfunction

   function automatic void queue_result(input int unsigned blk, input rsp_status_type st,
                                        input bit lst, input int unsigned fr);
      alloc_rsp_type r;
      r.granted  = IDX_W'(blk);
      r.status   = st;
      r.last     = lst;
      r.free_cnt = CNT_W'(fr);
      due_results.push_back(r);
   endfunction

   // Apply one accepted request to the shadow map and queue its results.
   function automatic void allocate_or_release(input alloc_req_type it);
      int unsigned t;
      int unsigned bs;
      int unsigned need;
      int unsigned fr;
      int unsigned got;
      int unsigned i;
      t = eff_total();
      if (it.action == ACT_FREE) begin
         if (it.block_index >= t) begin
            queue_result(0, ST_RANGE, 1'b1, blocks_free());
         end else begin
            shadow_used[it.block_index] = 1'b0;
            queue_result(0, ST_OK, 1'b1, blocks_free());
         end
      end else if (it.byte_size == 0) begin
         queue_result(0, ST_ZERO, 1'b1, blocks_free());
      end else begin
         bs   = eff_bsize();
         need = (it.byte_size + bs - 1) / bs;
         fr   = blocks_free();
         if (need > MAX_PER_REQUEST || need > fr) begin
            queue_result(0, ST_NO_SPACE, 1'b1, fr);
         end else begin
            // First fit: hand out the lowest free blocks in order.
            fr  = fr - need;
            got = 0;
            for (i = 0; i < t && got < need; i++) begin
               if (!shadow_used[i]) begin
                  shadow_used[i] = 1'b1;
                  got++;
                  queue_result(i, ST_OK, got == need, fr);
               end
            end
         end
      end
   endfunction

   // Request driver: offers queued beats, idling at random between them.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            allocate_or_release(req_cur);
         end
         if (!req_tvalid || req_tready) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_cur = req_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= req_cur.action;
               req_tdata  <= REQ_TDATA_W'({req_cur.block_index, req_cur.byte_size});
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("mismatch at result beat %0d: %s got %0d expected %0d",
               rsp_beats, what, got, want);
      mismatch_count++;
   endtask

   // Result monitor: checks each beat against the oldest expectation.
   always @(posedge clock) begin
      alloc_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               report_mismatch("beat with none expected, granted_block", rsp_tdata[7:0], 0);
            end else begin
               want = due_results.pop_front();
               if (rsp_tdata[7:0] !== want.granted)
                  report_mismatch("granted_block", rsp_tdata[7:0], want.granted);
               if (rsp_tuser !== want.status)
                  report_mismatch("status", rsp_tuser, want.status);
               if (rsp_tlast !== want.last)
                  report_mismatch("last", rsp_tlast, want.last);
               if (rsp_tdata[16:8] !== want.free_cnt)
                  report_mismatch("free_blocks", rsp_tdata[16:8], want.free_cnt);
            end
            rsp_beats++;
         end
         rsp_tready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic void add_alloc(input int unsigned size);
      alloc_req_type it;
      it.action      = ACT_ALLOC;
      it.byte_size   = SIZE_W'(size);
      it.block_index = IDX_W'($urandom_range(255));
      req_backlog.push_back(it);
   endfunction

   function automatic void add_free(input int unsigned idx);
      alloc_req_type it;
      it.action      = ACT_FREE;
      it.byte_size   = SIZE_W'($urandom_range(4095));
      it.block_index = IDX_W'(idx);
      req_backlog.push_back(it);
   endfunction

   // Mostly sized allocations and releases of in-range blocks, some noise.
   function automatic void add_random(input int unsigned count);
      int unsigned k;
      int unsigned r;
      int unsigned need;
      int unsigned bs;
      bs = eff_bsize();
      for (k = 0; k < count; k++) begin
         r = $urandom_range(99);
         if ($urandom_range(1)) begin
            if (r < 3) begin
               add_alloc(0);
            end else if (r < 13) begin
               add_alloc($urandom_range(4095));
            end else begin
               need = (r < 33) ? $urandom_range(5, MAX_PER_REQUEST + 1) : $urandom_range(1, 4);
               add_alloc((need - 1) * bs + $urandom_range(1, bs));
            end
         end else if (r < 85) begin
            add_free($urandom_range(eff_total() - 1));
         end else begin
            add_free($urandom_range(255));
         end
      end
   endfunction

   // Wait until every request has been taken and every result checked.
   // Sampled on the falling edge, after the driver and monitor have settled.
   task automatic wait_drained();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_tvalid || due_results.size() != 0);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_TOTAL_BLOCKS) cfg_total = TOTAL_W'(value);
      else                         cfg_bsize = BS_W'(value);
   endtask

   // Settings change only once the block has gone quiet.
   task automatic apply_settings(input int unsigned total, input int unsigned bsize);
      wait_drained();
      repeat (20) @(posedge clock);
      csr_write(CSR_TOTAL_BLOCKS, CSR_DATA_W'(total));
      csr_write(CSR_BLOCK_SIZE, CSR_DATA_W'(bsize));
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Sender idles a little, receiver a lot; default 16 blocks of 32 bytes.
      send_idle_pct <= 14;
      recv_idle_pct <= 62;
      add_alloc(0);
      add_alloc(1);
      add_alloc(32);
      add_alloc(33);
      add_alloc(4095);
      add_alloc(512);
      add_free(0);
      add_free(0);
      add_free(15);
      add_free(16);
      add_free(255);
      add_alloc(1);
      add_alloc(384);
      add_alloc(1);
      add_free(7);
      add_free(3);
      add_alloc(64);
      add_random(40);

      // Full map of one-byte blocks: largest grant, per-request limit, top index.
      apply_settings(256, 1);
      add_alloc(16);
      add_alloc(17);
      add_free(255);
      add_free(8);
      add_random(15);
      wait_drained();

      // Receiver holds off long enough for the block to back up its input.
      add_random(25);
      rsp_hold <= 1'b1;
      repeat (400) @(posedge clock);
      rsp_hold <= 1'b0;

      // Roles swapped: the sender is the slow side.
      apply_settings(1, 64);
      send_idle_pct <= 62;
      recv_idle_pct <= 14;
      add_random(30);
      apply_settings(0, 0);
      add_random(30);

      // No idling on either side.
      apply_settings(511, 127);
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      add_random(40);
      apply_settings(40, 7);
      add_random(40);
      apply_settings(300, 64);
      add_random(30);

      wait_drained();
      repeat (200) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #6_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
